/* rtl/kle_pkg.sv */
package kle_pkg;

  // key codes
  localparam logic [7:0] KEY_BS        = 8'h08;
  localparam logic [7:0] KEY_LF        = 8'h0a;
  localparam logic [7:0] KEY_CR        = 8'h0d;
  localparam logic [7:0] KEY_ETX       = 8'h03;
  localparam logic [7:0] KEY_ESC_ASCII = 8'h1b;
  localparam logic [7:0] KEY_ESC       = 8'hb1;
  localparam logic [7:0] KEY_LEFT      = 8'hb4;
  localparam logic [7:0] KEY_RIGHT     = 8'hb7;
  localparam logic [7:0] KEY_HOME      = 8'hd2;
  localparam logic [7:0] KEY_DEL       = 8'hd4;
  localparam logic [7:0] KEY_END       = 8'hd5;
  localparam logic [7:0] KEY_SPACE     = 8'h20;
  localparam logic [7:0] KEY_TILDE     = 8'h7e;
  localparam logic [7:0] KEY_FN_FIRST  = 8'h81;
  localparam logic [7:0] KEY_FN_LAST   = 8'h89;
  localparam logic [7:0] KEY_FN_EXTRA  = 8'h90;

  // result event codes
  localparam logic [2:0] EV_IGNORED = 3'd0;
  localparam logic [2:0] EV_MOVED   = 3'd1;
  localparam logic [2:0] EV_EDITED  = 3'd2;
  localparam logic [2:0] EV_DONE    = 3'd3;
  localparam logic [2:0] EV_CANCEL  = 3'd4;
  localparam logic [2:0] EV_SPECIAL = 3'd5;

  // reset value of the length limit
  localparam logic [5:0] MAX_LENGTH_RESET = 6'd63;

  // what every character cell does in a cycle
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_SHIFT_OUT
  } cell_op_t;

  typedef struct packed {
    cell_op_t   op;
    logic [6:0] key;
  } cell_cmd_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

endpackage

/* rtl/keystroke_line_editor.sv */
// channel | signals                                   | transfer when
// --------+-------------------------------------------+------------------------
// in      | in_valid, in_ready, in_key_code           | in_valid & in_ready
// out     | out_valid, out_ready, out_event_res,      | out_valid & out_ready
//         | out_line_char, out_has_char,              |
//         | out_special_key_code, out_cursor_pos,     |
//         | out_line_length, out_last_of_run          |
// cfg     | cfg_valid, cfg_ready, cfg_max_length      | cfg_valid & cfg_ready
//
// a key is decoded and the character row updated in the cycle of its transfer;
// its result sits in the output register from the next cycle on
// enter on a line of n characters shifts the row of cells towards cell 0 in the
// emit state, one character out per cycle while the output is not stalled
// a new key is taken only in the idle state with the output register free or
// being emptied; a stalled output holds the row and the controller
// rst_n clears cursor, length and the control state and sets the limit to 63; cells hold no reset
module keystroke_line_editor #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_key_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_event_res,
  output logic [6:0] out_line_char,
  output logic       out_has_char,
  output logic [7:0] out_special_key_code,
  output logic [5:0] out_cursor_pos,
  output logic [5:0] out_line_length,
  output logic       out_last_of_run,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] cfg_max_length
);

  localparam int CW    = $clog2(LINE_CAPACITY);
  localparam int LW    = (CW > 6) ? CW : 6;
  localparam int NCELL = LINE_CAPACITY - 1;

  kle_pkg::state_t    state_r, state_nxt;
  logic [CW-1:0]      cursor_r, cursor_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      remain_r, remain_nxt;
  logic [5:0]         max_length_r;
  logic [LW-1:0]      limit;

  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         ev_r, ev_nxt;
  logic [6:0]         ch_r, ch_nxt;
  logic               has_r, has_nxt;
  logic [7:0]         spec_r, spec_nxt;
  logic [5:0]         cur_r, cur_nxt;
  logic [5:0]         len_r, len_nxt;
  logic               last_r, last_nxt;

  logic               out_free;
  logic               in_fire;
  logic               report_before;

  kle_pkg::cell_cmd_t cmd;
  logic [CW-1:0]      cmd_pos;
  logic [6:0]         cell_q [NCELL];

  // handshakes
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == kle_pkg::ST_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // limit in force: smaller of the register and the row length
  assign limit = (LW'(max_length_r) < LW'(NCELL)) ? LW'(max_length_r) : LW'(NCELL);

  // key decode, emit sequencing and result build
  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    count_nxt     = count_r;
    remain_nxt    = remain_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ev_nxt        = ev_r;
    ch_nxt        = ch_r;
    has_nxt       = has_r;
    spec_nxt      = spec_r;
    cur_nxt       = cur_r;
    len_nxt       = len_r;
    last_nxt      = last_r;
    report_before = 1'b0;
    cmd.op        = kle_pkg::OP_HOLD;
    cmd.key       = in_key_code[6:0];
    cmd_pos       = cursor_r;

    if (in_fire) begin
      out_valid_nxt = 1'b1;
      ev_nxt        = kle_pkg::EV_IGNORED;
      ch_nxt        = 7'd0;
      has_nxt       = 1'b0;
      spec_nxt      = 8'd0;
      last_nxt      = 1'b1;
      case (in_key_code) inside
        kle_pkg::KEY_LF, kle_pkg::KEY_CR: begin
          if (count_r == '0) begin
            ev_nxt = kle_pkg::EV_DONE;
          end else begin
            // line goes out over the next cycles
            out_valid_nxt = 1'b0;
            remain_nxt    = count_r;
            state_nxt     = kle_pkg::ST_EMIT;
          end
        end
        kle_pkg::KEY_ESC, kle_pkg::KEY_ESC_ASCII, kle_pkg::KEY_ETX: begin
          ev_nxt        = kle_pkg::EV_CANCEL;
          report_before = 1'b1;
          cursor_nxt    = '0;
          count_nxt     = '0;
        end
        kle_pkg::KEY_LEFT: begin
          if (cursor_r != '0) begin
            cursor_nxt = cursor_r - CW'(1);
            ev_nxt     = kle_pkg::EV_MOVED;
          end
        end
        kle_pkg::KEY_RIGHT: begin
          if (cursor_r < count_r) begin
            cursor_nxt = cursor_r + CW'(1);
            ev_nxt     = kle_pkg::EV_MOVED;
          end
        end
        kle_pkg::KEY_HOME: begin
          if (count_r == '0) begin
            ev_nxt   = kle_pkg::EV_SPECIAL;
            spec_nxt = in_key_code;
          end else begin
            cursor_nxt = '0;
            ev_nxt     = kle_pkg::EV_MOVED;
          end
        end
        [kle_pkg::KEY_FN_FIRST:kle_pkg::KEY_FN_LAST], kle_pkg::KEY_FN_EXTRA: begin
          if (count_r == '0) begin
            ev_nxt   = kle_pkg::EV_SPECIAL;
            spec_nxt = in_key_code;
          end
        end
        kle_pkg::KEY_END: begin
          cursor_nxt = count_r;
          ev_nxt     = kle_pkg::EV_MOVED;
        end
        kle_pkg::KEY_BS: begin
          if (cursor_r != '0) begin
            cmd.op     = kle_pkg::OP_REMOVE;
            cmd_pos    = cursor_r - CW'(1);
            cursor_nxt = cursor_r - CW'(1);
            count_nxt  = count_r - CW'(1);
            ev_nxt     = kle_pkg::EV_EDITED;
          end
        end
        kle_pkg::KEY_DEL: begin
          if (cursor_r < count_r) begin
            cmd.op    = kle_pkg::OP_REMOVE;
            count_nxt = count_r - CW'(1);
            ev_nxt    = kle_pkg::EV_EDITED;
          end
        end
        [kle_pkg::KEY_SPACE:kle_pkg::KEY_TILDE]: begin
          if (LW'(count_r) < limit) begin
            cmd.op     = kle_pkg::OP_INSERT;
            cursor_nxt = cursor_r + CW'(1);
            count_nxt  = count_r + CW'(1);
            ev_nxt     = kle_pkg::EV_EDITED;
          end
        end
        default: begin
          ev_nxt = kle_pkg::EV_IGNORED;
        end
      endcase
      if (report_before) begin
        cur_nxt = 6'(cursor_r);
        len_nxt = 6'(count_r);
      end else begin
        cur_nxt = 6'(cursor_nxt);
        len_nxt = 6'(count_nxt);
      end
    end else if (state_r == kle_pkg::ST_EMIT && out_free) begin
      // one character of the finished line from cell 0
      out_valid_nxt = 1'b1;
      ev_nxt        = kle_pkg::EV_DONE;
      ch_nxt        = cell_q[0];
      has_nxt       = 1'b1;
      spec_nxt      = 8'd0;
      cur_nxt       = 6'(count_r);
      len_nxt       = 6'(count_r);
      last_nxt      = (remain_r == CW'(1));
      cmd.op        = kle_pkg::OP_SHIFT_OUT;
      remain_nxt    = remain_r - CW'(1);
      if (remain_r == CW'(1)) begin
        cursor_nxt = '0;
        count_nxt  = '0;
        state_nxt  = kle_pkg::ST_IDLE;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= kle_pkg::ST_IDLE;
      cursor_r     <= '0;
      count_r      <= '0;
      remain_r     <= '0;
      out_valid_r  <= 1'b0;
      max_length_r <= kle_pkg::MAX_LENGTH_RESET;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      count_r     <= count_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        max_length_r <= cfg_max_length;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    ev_r   <= ev_nxt;
    ch_r   <= ch_nxt;
    has_r  <= has_nxt;
    spec_r <= spec_nxt;
    cur_r  <= cur_nxt;
    len_r  <= len_nxt;
    last_r <= last_nxt;
  end

  // row of character cells
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic [6:0] left_w;
    logic [6:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = 7'd0;
    end else begin : g_mid_left
      assign left_w = cell_q[i-1];
    end
    if (i == NCELL - 1) begin : g_last
      assign right_w = 7'd0;
    end else begin : g_mid_right
      assign right_w = cell_q[i+1];
    end
    kle_cell #(
      .IDX   (i),
      .POS_W (CW)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .pos        (cmd_pos),
      .left_char  (left_w),
      .right_char (right_w),
      .char_q     (cell_q[i])
    );
  end

  assign out_valid            = out_valid_r;
  assign out_event_res        = ev_r;
  assign out_line_char        = ch_r;
  assign out_has_char         = has_r;
  assign out_special_key_code = spec_r;
  assign out_cursor_pos       = cur_r;
  assign out_line_length      = len_r;
  assign out_last_of_run      = last_r;

endmodule

/* rtl/kle_cell.sv */
module kle_cell #(
  parameter int IDX   = 0,
  parameter int POS_W = 6
) (
  input  logic                clk,
  input  kle_pkg::cell_cmd_t  cmd,
  input  logic [POS_W-1:0]    pos,
  input  logic [6:0]          left_char,
  input  logic [6:0]          right_char,
  output logic [6:0]          char_q
);

  logic [6:0] char_r;
  logic [6:0] char_nxt;

  // next character from the neighbours or the new key
  always_comb begin
    char_nxt = char_r;
    case (cmd.op)
      kle_pkg::OP_INSERT: begin
        if (POS_W'(IDX) > pos) begin
          char_nxt = left_char;
        end else if (POS_W'(IDX) == pos) begin
          char_nxt = cmd.key;
        end
      end
      kle_pkg::OP_REMOVE: begin
        if (POS_W'(IDX) >= pos) begin
          char_nxt = right_char;
        end
      end
      kle_pkg::OP_SHIFT_OUT: begin
        char_nxt = right_char;
      end
      default: begin
        char_nxt = char_r;
      end
    endcase
  end

  // character storage, no reset
  always_ff @(posedge clk) begin
    char_r <= char_nxt;
  end

  assign char_q = char_r;

endmodule

/* tb/line_editor_checker.sv */
module line_editor_checker #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_key_code,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [2:0] out_event_res,
  input  logic [6:0] out_line_char,
  input  logic       out_has_char,
  input  logic [7:0] out_special_key_code,
  input  logic [5:0] out_cursor_pos,
  input  logic [5:0] out_line_length,
  input  logic       out_last_of_run,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [5:0] cfg_max_length,
  output int         mismatch_count,
  output int         results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0] ev;
    logic [6:0] ch;
    logic       has_ch;
    logic [7:0] spec;
    logic [5:0] cur;
    logic [5:0] len;
    logic       last;
  } key_result_t;

  // results owed by the block, oldest first
  key_result_t owed_results[$];

  // shadow of the edit line
  logic [6:0] line_chars [LINE_CAPACITY];
  int         edit_cursor;
  int         edit_length;
  int         max_length_reg;

  function automatic void owe(logic [2:0] ev, logic [6:0] ch, logic has_ch, logic [7:0] spec,
                              int cur, int len, logic last);
    key_result_t r;
    r.ev     = ev;
    r.ch     = ch;
    r.has_ch = has_ch;
    r.spec   = spec;
    r.cur    = cur[5:0];
    r.len    = len[5:0];
    r.last   = last;
    owed_results.push_back(r);
  endfunction

  // works out what one key does to the line and which results it gives
  function automatic void predict_key(logic [7:0] k);
    logic [2:0] ev;
    int         limit;
    int         i;
    logic       fn_key;
    ev     = kle_pkg::EV_IGNORED;
    limit  = (max_length_reg < LINE_CAPACITY - 1) ? max_length_reg : LINE_CAPACITY - 1;
    fn_key = (k >= kle_pkg::KEY_FN_FIRST && k <= kle_pkg::KEY_FN_LAST)
             || k == kle_pkg::KEY_FN_EXTRA;
    if (k == kle_pkg::KEY_LF || k == kle_pkg::KEY_CR) begin
      // enter: the whole line goes out, one character per result
      if (edit_length == 0) begin
        owe(kle_pkg::EV_DONE, 7'd0, 1'b0, 8'd0, 0, 0, 1'b1);
      end else begin
        for (i = 0; i < edit_length; i++)
          owe(kle_pkg::EV_DONE, line_chars[i], 1'b1, 8'd0, edit_length, edit_length,
              i == edit_length - 1);
      end
      edit_cursor = 0;
      edit_length = 0;
    end else if (k == kle_pkg::KEY_ESC || k == kle_pkg::KEY_ESC_ASCII
                 || k == kle_pkg::KEY_ETX) begin
      // cancel reports the line as it stood
      owe(kle_pkg::EV_CANCEL, 7'd0, 1'b0, 8'd0, edit_cursor, edit_length, 1'b1);
      edit_cursor = 0;
      edit_length = 0;
    end else if ((k == kle_pkg::KEY_HOME || fn_key) && edit_length == 0) begin
      owe(kle_pkg::EV_SPECIAL, 7'd0, 1'b0, k, 0, 0, 1'b1);
      edit_cursor = 0;
      edit_length = 0;
    end else begin
      if (k == kle_pkg::KEY_LEFT) begin
        if (edit_cursor > 0) begin
          edit_cursor--;
          ev = kle_pkg::EV_MOVED;
        end
      end else if (k == kle_pkg::KEY_RIGHT) begin
        if (edit_cursor < edit_length) begin
          edit_cursor++;
          ev = kle_pkg::EV_MOVED;
        end
      end else if (k == kle_pkg::KEY_HOME) begin
        edit_cursor = 0;
        ev = kle_pkg::EV_MOVED;
      end else if (k == kle_pkg::KEY_END) begin
        edit_cursor = edit_length;
        ev = kle_pkg::EV_MOVED;
      end else if (k == kle_pkg::KEY_BS) begin
        // close the gap left of the cursor
        if (edit_cursor > 0 && edit_cursor <= edit_length) begin
          for (i = edit_cursor; i < edit_length; i++)
            line_chars[i-1] = line_chars[i];
          edit_cursor--;
          edit_length--;
          ev = kle_pkg::EV_EDITED;
        end
      end else if (k == kle_pkg::KEY_DEL) begin
        // close the gap under the cursor
        if (edit_cursor < edit_length) begin
          for (i = edit_cursor + 1; i < edit_length; i++)
            line_chars[i-1] = line_chars[i];
          edit_length--;
          ev = kle_pkg::EV_EDITED;
        end
      end else if (k >= kle_pkg::KEY_SPACE && k <= kle_pkg::KEY_TILDE && edit_length < limit
                   && edit_cursor <= edit_length) begin
        // open a gap at the cursor and insert
        for (i = edit_length; i > edit_cursor; i--)
          line_chars[i] = line_chars[i-1];
        line_chars[edit_cursor] = k[6:0];
        edit_cursor++;
        edit_length++;
        ev = kle_pkg::EV_EDITED;
      end
      owe(ev, 7'd0, 1'b0, 8'd0, edit_cursor, edit_length, 1'b1);
    end
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // compare one result transfer with the oldest owed result
  function automatic void check_result();
    key_result_t want;
    if (owed_results.size() == 0) begin
      $display("%0t: result expected none got event %0d char %0d cursor %0d length %0d",
               $time, out_event_res, out_line_char, out_cursor_pos, out_line_length);
      mismatch_count++;
    end else begin
      want = owed_results.pop_front();
      compare_field("event_res", 8'(want.ev), 8'(out_event_res));
      compare_field("line_char", 8'(want.ch), 8'(out_line_char));
      compare_field("has_char", 8'(want.has_ch), 8'(out_has_char));
      compare_field("special_key_code", want.spec, out_special_key_code);
      compare_field("cursor_pos", 8'(want.cur), 8'(out_cursor_pos));
      compare_field("line_length", 8'(want.len), 8'(out_line_length));
      compare_field("last_of_run", 8'(want.last), 8'(out_last_of_run));
    end
  endfunction

  // watch the three channels
  always @(posedge clk) begin
    if (!rst_n) begin
      owed_results.delete();
      edit_cursor    = 0;
      edit_length    = 0;
      max_length_reg = int'(kle_pkg::MAX_LENGTH_RESET);
      mismatch_count = 0;
    end else begin
      if (out_valid && out_ready)
        check_result();
      if (cfg_valid && cfg_ready)
        max_length_reg = int'(cfg_max_length);
      if (in_valid && in_ready)
        predict_key(in_key_code);
    end
    results_owed <= owed_results.size();
  end

endmodule

/* tb/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_KEYS  = 180;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 1000000;

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_ready;
  logic [7:0] in_key_code    = 8'd0;
  logic       out_valid;
  logic       out_ready      = 1'b0;
  logic [2:0] out_event_res;
  logic [6:0] out_line_char;
  logic       out_has_char;
  logic [7:0] out_special_key_code;
  logic [5:0] out_cursor_pos;
  logic [5:0] out_line_length;
  logic       out_last_of_run;
  logic       cfg_valid      = 1'b0;
  logic       cfg_ready;
  logic [5:0] cfg_max_length = 6'd0;

  int         mismatch_count;
  int         results_owed;
  int         keys_sent   = 0;
  int         cycle_count = 0;
  int         in_quiet    = 0;
  int         out_quiet   = 0;
  logic [7:0] directed_keys[$];

  keystroke_line_editor i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_key_code         (in_key_code),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_event_res       (out_event_res),
    .out_line_char       (out_line_char),
    .out_has_char        (out_has_char),
    .out_special_key_code(out_special_key_code),
    .out_cursor_pos      (out_cursor_pos),
    .out_line_length     (out_line_length),
    .out_last_of_run     (out_last_of_run),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_max_length      (cfg_max_length)
  );

  line_editor_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_key_code         (in_key_code),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_event_res       (out_event_res),
    .out_line_char       (out_line_char),
    .out_has_char        (out_has_char),
    .out_special_key_code(out_special_key_code),
    .out_cursor_pos      (out_cursor_pos),
    .out_line_length     (out_line_length),
    .out_last_of_run     (out_last_of_run),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_max_length      (cfg_max_length),
    .mismatch_count      (mismatch_count),
    .results_owed        (results_owed)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle cycles before a transfer, with quiet stretches of none
  function automatic int pick_idle_cycles(inout int quiet);
    int cycles;
    cycles = 0;
    if (quiet > 0)
      quiet--;
    else if ($urandom_range(0, 19) == 0)
      quiet = $urandom_range(4, 30);
    else
      cycles = $urandom_range(0, 14);
    return cycles;
  endfunction

  // mostly well-formed editing, some noise
  function automatic logic [7:0] random_key();
    int pick;
    int fn;
    pick = $urandom_range(0, 99);
    if (pick < 45)      return 8'($urandom_range(kle_pkg::KEY_SPACE, kle_pkg::KEY_TILDE));
    else if (pick < 53) return kle_pkg::KEY_LEFT;
    else if (pick < 58) return kle_pkg::KEY_RIGHT;
    else if (pick < 62) return kle_pkg::KEY_HOME;
    else if (pick < 66) return kle_pkg::KEY_END;
    else if (pick < 72) return kle_pkg::KEY_BS;
    else if (pick < 77) return kle_pkg::KEY_DEL;
    else if (pick < 84) return $urandom_range(0, 1) ? kle_pkg::KEY_LF : kle_pkg::KEY_CR;
    else if (pick < 87) begin
      fn = $urandom_range(0, 2);
      return (fn == 0) ? kle_pkg::KEY_ESC :
             (fn == 1) ? kle_pkg::KEY_ESC_ASCII : kle_pkg::KEY_ETX;
    end else if (pick < 91) begin
      fn = $urandom_range(0, 9);
      return (fn == 9) ? kle_pkg::KEY_FN_EXTRA : kle_pkg::KEY_FN_FIRST + 8'(fn);
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // one key transfer; valid stays high afterwards
  task automatic send_key(input logic [7:0] k);
    int gap;
    gap = pick_idle_cycles(in_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_key_code <= k;
    do @(posedge clk); while (!in_ready);
    keys_sent++;
  endtask

  // stop sending and wait until every owed result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  task automatic write_max_length(input logic [5:0] value);
    cfg_valid      <= 1'b1;
    cfg_max_length <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // result side stalls
  initial begin
    int stall;
    @(posedge clk);
    forever begin
      stall = pick_idle_cycles(out_quiet);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    int phase;
    int batch;
    int random_start;
    int limit_pick;
    logic [5:0] limit;
    directed_keys = '{kle_pkg::KEY_CR, kle_pkg::KEY_HOME, kle_pkg::KEY_FN_FIRST,
                      kle_pkg::KEY_FN_LAST, kle_pkg::KEY_FN_EXTRA,
                      kle_pkg::KEY_LEFT, kle_pkg::KEY_BS, kle_pkg::KEY_DEL, kle_pkg::KEY_END,
                      kle_pkg::KEY_SPACE, kle_pkg::KEY_TILDE, 8'h41, kle_pkg::KEY_RIGHT,
                      kle_pkg::KEY_LEFT, kle_pkg::KEY_LEFT, 8'h5a,
                      kle_pkg::KEY_HOME, kle_pkg::KEY_DEL, 8'h85, 8'h7f, 8'h00, 8'hff,
                      kle_pkg::KEY_END, kle_pkg::KEY_BS, kle_pkg::KEY_LF,
                      8'h71, kle_pkg::KEY_ESC, kle_pkg::KEY_ESC_ASCII, 8'h78,
                      kle_pkg::KEY_ETX};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed keys at the reset limit
    foreach (directed_keys[i])
      send_key(directed_keys[i]);
    wait_drained();
    random_start = keys_sent;

    // fill the line past the top limit, emit it, leave a short line standing
    write_max_length(6'd63);
    repeat (66) send_key(8'($urandom_range(kle_pkg::KEY_SPACE, kle_pkg::KEY_TILDE)));
    send_key(kle_pkg::KEY_LEFT);
    send_key(kle_pkg::KEY_DEL);
    send_key(8'h40);
    send_key(kle_pkg::KEY_HOME);
    send_key(kle_pkg::KEY_CR);
    repeat (12) send_key(8'($urandom_range(kle_pkg::KEY_SPACE, kle_pkg::KEY_TILDE)));
    wait_drained();

    // random phases, each under its own limit
    phase = 0;
    while (keys_sent - random_start < RANDOM_KEYS) begin
      limit_pick = $urandom_range(0, 7);
      if (phase == 0)           limit = 6'd0;
      else if (phase == 1)      limit = 6'd1;
      else if (limit_pick == 0) limit = 6'd0;
      else if (limit_pick == 1) limit = 6'd63;
      else if (limit_pick < 4)  limit = 6'($urandom_range(1, 8));
      else                      limit = 6'($urandom_range(0, 63));
      write_max_length(limit);
      batch = $urandom_range(20, 30);
      repeat (batch) send_key(random_key());
      wait_drained();
      phase++;
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
